### hdl/ufd_pkg.sv
// ----------------------------------------------------------------------------
// ufd_pkg : shared types and constants for the UART edge-event decoder
// Field widths, register indexes, offset select codes and the control word
// of the shared add/compare unit.
// ----------------------------------------------------------------------------
package ufd_pkg;

    // payload and register widths
    localparam int DATA_W    = 9;
    localparam int ACC_W     = 10;   // data bits plus parity bit
    localparam int CNT_W     = 4;
    localparam int PER_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 24;
    localparam int DB_W      = 4;
    localparam int PM_W      = 2;
    localparam int OFF_W     = 29;   // n * period + period / 2, n up to ten
    localparam int FRAC_W    = 8;
    localparam int STAMP_W   = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PARITY     = 2'd2;

    // register reset values
    localparam logic [PER_W-1:0] RST_BIT_PERIOD = 24'd1111;
    localparam logic [DB_W-1:0]  RST_DATA_BITS  = 4'd8;
    localparam logic [PM_W-1:0]  RST_PARITY     = 2'd0;

    // data bit count limits
    localparam logic [DB_W-1:0] DB_MIN = 4'd5;
    localparam logic [DB_W-1:0] DB_MAX = 4'd9;
    localparam logic [PM_W-1:0] PM_NONE = 2'd0;

    // item kinds
    localparam logic KIND_EDGE  = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // adder offset selects
    localparam logic [1:0] OFF_STEP  = 2'd0;   // one bit period
    localparam logic [1:0] OFF_FIRST = 2'd1;   // one and a half periods
    localparam logic [1:0] OFF_GUARD = 2'd2;   // (2n+1)/2 periods

    typedef struct packed {
        logic       probe_cmp;  // compare probe time, else guard time
        logic       probe_add;  // add onto probe time, else edge time
        logic [1:0] off_sel;
    } t_alu_ctl;

endpackage

### hdl/ufd_alu.sv
// ----------------------------------------------------------------------------
// ufd_alu : shared saturating time adder and comparator
// One add (saturating at the top of the Q8 time range) and one less-than
// compare against the edge time, reused by the walk, start and guard steps.
// ----------------------------------------------------------------------------
module ufd_alu
    import ufd_pkg::*;
#(
    parameter int TQ_W = 40
) (
    input  t_alu_ctl         i_ctl,
    input  logic [TQ_W-1:0]  i_probe,
    input  logic [TQ_W-1:0]  i_guard,
    input  logic [TQ_W-1:0]  i_tq,
    input  logic [PER_W-1:0] i_period,
    input  logic [CNT_W-1:0] i_nbits,
    output logic [TQ_W-1:0]  o_sum,
    output logic             o_lt
);

    localparam int SUM_W = ((TQ_W > OFF_W) ? TQ_W : OFF_W) + 1;

    logic [OFF_W-1:0] w_half;
    logic [OFF_W-1:0] w_off;
    logic [TQ_W-1:0]  w_a;
    logic [SUM_W-1:0] w_sum;

    assign w_half = OFF_W'(i_period >> 1);

    always_comb begin
        case (i_ctl.off_sel)
            OFF_STEP:  w_off = OFF_W'(i_period);
            OFF_FIRST: w_off = OFF_W'(i_period) + w_half;
            OFF_GUARD: w_off = (OFF_W'(i_nbits) * OFF_W'(i_period)) + w_half;
            default:   w_off = OFF_W'(i_period);
        endcase
    end

    assign w_a   = i_ctl.probe_add ? i_probe : i_tq;
    assign w_sum = SUM_W'(w_a) + SUM_W'(w_off);
    assign o_sum = (w_sum > SUM_W'({TQ_W{1'b1}})) ? {TQ_W{1'b1}} : w_sum[TQ_W-1:0];

    // probe (or guard) strictly before the event time
    assign o_lt = (i_ctl.probe_cmp ? i_probe : i_guard) < i_tq;

endmodule

### hdl/uart_frame_decoder_from_edges.sv
// ----------------------------------------------------------------------------
// uart_frame_decoder_from_edges : UART frames from timestamped line events
// Waits for idle high, starts a frame on a falling edge past the guard time,
// samples data and parity LSB first at 1.5, 2.5 ... bit periods after the edge
// using the level in force just before each probe. A flush closes the frame.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Handshake                  | Payload
//  --------+-----+----------------------------+------------------------------
//  in      | in  | i_in_valid / o_in_ready    | i_kind, i_timestamp, i_level
//  out     | out | o_out_valid / i_out_ready  | o_data, o_parity_bit,
//          |     |                            | o_start_time
//  cfg     | in  | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
//  Steps: one beat at a time; an event is accepted and checked, then (once
//  idle was seen) walks the probes it passed while a frame is open, emits a
//  full frame, and is tested for a start, setting the guard time if one opens.
//  A flush is accepted and checked, and goes to the emit step if it closes a frame.
//  Reset (synchronous, active low) clears the decoder and reloads the
//  register defaults. A stalled output holds the emit step until taken.
// ----------------------------------------------------------------------------
module uart_frame_decoder_from_edges
    import ufd_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // input beats
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_kind,
    input  logic [STAMP_W-1:0]   i_timestamp,
    input  logic                 i_level,
    // result beats
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [DATA_W-1:0]    o_data,
    output logic                 o_parity_bit,
    output logic [STAMP_W-1:0]   o_start_time
);

    localparam int TQ_W  = TIME_WIDTH + FRAC_W;
    localparam int EXT_W = (TIME_WIDTH > STAMP_W) ? TIME_WIDTH : STAMP_W;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_START = 3'd4;
    localparam logic [2:0] S_GUARD = 3'd5;

    // configuration registers
    logic [PER_W-1:0] r_period;
    logic [DB_W-1:0]  r_dbits;
    logic [PM_W-1:0]  r_pmode;

    // sequencer and decoder state
    logic [2:0]         r_state, n_state;
    logic               r_seen_idle, n_seen_idle;
    logic               r_prev, n_prev;
    logic               r_in_frame, n_in_frame;
    logic [TQ_W-1:0]    r_probe, n_probe;
    logic [TQ_W-1:0]    r_guard, n_guard;
    logic [CNT_W-1:0]   r_bits, n_bits;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [STAMP_W-1:0] r_fstart, n_fstart;

    // captured beat
    logic               r_kind, n_kind;
    logic               r_lvl, n_lvl;
    logic [TQ_W-1:0]    r_tq, n_tq;
    logic [STAMP_W-1:0] r_ts, n_ts;

    // output register
    logic               r_out_valid, n_out_valid;
    logic [DATA_W-1:0]  r_data, n_data;
    logic               r_par, n_par;
    logic [STAMP_W-1:0] r_ostart, n_ostart;

    logic [DB_W-1:0]    w_db;
    logic [CNT_W-1:0]   w_total;
    logic               w_in_acc;
    logic               w_out_free;
    logic [EXT_W-1:0]   w_ts_ext;
    logic [TIME_WIDTH-1:0] w_ts_tw;
    logic [ACC_W-1:0]   w_fill;
    logic [DATA_W-1:0]  w_data;
    logic               w_step;
    t_alu_ctl           w_ctl;
    logic [TQ_W-1:0]    w_sum;
    logic               w_lt;

    // effective frame length from the live registers
    always_comb begin
        if (r_dbits < DB_MIN) begin
            w_db = DB_MIN;
        end else if (r_dbits > DB_MAX) begin
            w_db = DB_MAX;
        end else begin
            w_db = r_dbits;
        end
    end
    assign w_total = w_db + CNT_W'(r_pmode != PM_NONE);

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // timestamp kept to TIME_WIDTH bits, then moved to Q8
    assign w_ts_ext = EXT_W'(i_timestamp);
    assign w_ts_tw  = w_ts_ext[TIME_WIDTH-1:0];

    // flush: every missing bit takes the current level
    always_comb begin
        for (int i = 0; i < ACC_W; i++) begin
            w_fill[i] = r_prev && (CNT_W'(i) >= r_bits) && (CNT_W'(i) < w_total);
        end
    end

    always_comb begin
        for (int i = 0; i < DATA_W; i++) begin
            w_data[i] = r_acc[i] && (DB_W'(i) < w_db);
        end
    end

    // shared unit control
    always_comb begin
        w_ctl.probe_cmp = (r_state == S_WALK);
        w_ctl.probe_add = (r_state == S_WALK);
        case (r_state)
            S_WALK:  w_ctl.off_sel = OFF_STEP;
            S_START: w_ctl.off_sel = OFF_FIRST;
            S_GUARD: w_ctl.off_sel = OFF_GUARD;
            default: w_ctl.off_sel = OFF_STEP;
        endcase
    end

    ufd_alu #(
        .TQ_W (TQ_W)
    ) u_alu (
        .i_ctl    (w_ctl),
        .i_probe  (r_probe),
        .i_guard  (r_guard),
        .i_tq     (r_tq),
        .i_period (r_period),
        .i_nbits  (w_total),
        .o_sum    (w_sum),
        .o_lt     (w_lt)
    );

    // one probe passed in this cycle
    assign w_step = (r_state == S_WALK) && (r_bits < w_total) && w_lt;

    always_comb begin
        n_state     = r_state;
        n_seen_idle = r_seen_idle;
        n_prev      = r_prev;
        n_in_frame  = r_in_frame;
        n_probe     = r_probe;
        n_guard     = r_guard;
        n_bits      = r_bits;
        n_acc       = r_acc;
        n_fstart    = r_fstart;
        n_kind      = r_kind;
        n_lvl       = r_lvl;
        n_tq        = r_tq;
        n_ts        = r_ts;
        n_out_valid = r_out_valid && !i_out_ready;
        n_data      = r_data;
        n_par       = r_par;
        n_ostart    = r_ostart;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_kind  = i_kind;
                    n_lvl   = i_level;
                    n_tq    = {w_ts_tw, {FRAC_W{1'b0}}};
                    n_ts    = STAMP_W'(w_ts_tw);
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_kind == KIND_FLUSH) begin
                    if (r_in_frame) begin
                        n_acc   = r_acc | w_fill;
                        n_state = S_EMIT;
                    end else begin
                        n_seen_idle = 1'b0;
                        n_prev      = 1'b0;
                        n_probe     = '0;
                        n_guard     = '0;
                        n_bits      = '0;
                        n_acc       = '0;
                        n_fstart    = '0;
                        n_state     = S_IDLE;
                    end
                end else if (!r_seen_idle) begin
                    n_seen_idle = r_lvl;
                    n_prev      = r_lvl;
                    n_state     = S_IDLE;
                end else if (r_in_frame) begin
                    n_state = S_WALK;
                end else begin
                    n_state = S_START;
                end
            end
            S_WALK: begin
                if (w_step) begin
                    n_acc[r_bits] = r_prev;
                    n_bits        = r_bits + CNT_W'(1);
                    n_probe       = w_sum;
                end else if (r_bits >= w_total) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_START;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_data      = w_data;
                    n_par       = (r_pmode != PM_NONE) && r_acc[w_db];
                    n_ostart    = r_fstart;
                    n_in_frame  = 1'b0;
                    if (r_kind == KIND_FLUSH) begin
                        n_seen_idle = 1'b0;
                        n_prev      = 1'b0;
                        n_probe     = '0;
                        n_guard     = '0;
                        n_bits      = '0;
                        n_acc       = '0;
                        n_fstart    = '0;
                        n_state     = S_IDLE;
                    end else begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                // falling edge past the guard time opens a frame
                if (!r_in_frame && r_prev && !r_lvl && w_lt) begin
                    n_in_frame = 1'b1;
                    n_bits     = '0;
                    n_acc      = '0;
                    n_fstart   = r_ts;
                    n_probe    = w_sum;
                    n_state    = S_GUARD;
                end else begin
                    n_prev  = r_lvl;
                    n_state = S_IDLE;
                end
            end
            S_GUARD: begin
                n_guard = w_sum;
                n_prev  = r_lvl;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= RST_BIT_PERIOD;
            r_dbits  <= RST_DATA_BITS;
            r_pmode  <= RST_PARITY;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BIT_PERIOD: r_period <= i_cfg_data[PER_W-1:0];
                CFG_DATA_BITS:  r_dbits  <= i_cfg_data[DB_W-1:0];
                CFG_PARITY:     r_pmode  <= i_cfg_data[PM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seen_idle <= 1'b0;
            r_prev      <= 1'b0;
            r_in_frame  <= 1'b0;
            r_probe     <= '0;
            r_guard     <= '0;
            r_bits      <= '0;
            r_acc       <= '0;
            r_fstart    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seen_idle <= n_seen_idle;
            r_prev      <= n_prev;
            r_in_frame  <= n_in_frame;
            r_probe     <= n_probe;
            r_guard     <= n_guard;
            r_bits      <= n_bits;
            r_acc       <= n_acc;
            r_fstart    <= n_fstart;
            r_out_valid <= n_out_valid;
        end
    end

    // captured beat and result payload
    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_lvl    <= n_lvl;
        r_tq     <= n_tq;
        r_ts     <= n_ts;
        r_data   <= n_data;
        r_par    <= n_par;
        r_ostart <= n_ostart;
    end

    assign o_out_valid  = r_out_valid;
    assign o_data       = r_data;
    assign o_parity_bit = r_par;
    assign o_start_time = r_ostart;

    // checks
    a_bits_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits <= CNT_W'(ACC_W))
        else $error("bit count beyond frame length");

    a_frame_needs_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_frame |-> r_seen_idle)
        else $error("frame open before idle seen");

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_in_ready)
        else $error("ready while a beat is in work");

    a_walk_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> (r_bits == $past(r_bits) + CNT_W'(1)))
        else $error("probe passed without taking a bit");

    a_emit_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_out_free) |=> (o_out_valid && !r_in_frame))
        else $error("emit step left frame open or no result");

endmodule
